// ===== design/fista_l1_coefficient_update_defines.svh =====
// ----------------------------------------------------------------------------
// FISTA L1 coefficient update - assertion macros
// Implication checks on the rising clock edge, masked while reset is low.
// ----------------------------------------------------------------------------
`ifndef FISTA_L1_COEFFICIENT_UPDATE_DEFINES_SVH
`define FISTA_L1_COEFFICIENT_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FL1CU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FL1CU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FL1CU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FL1CU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/fl1cu_pkg.sv =====
// ----------------------------------------------------------------------------
// fl1cu_pkg
// Shared sizes, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fl1cu_pkg;

    localparam int VECTOR_LENGTH = 1024;
    localparam int POS_W         = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

    localparam int DATA_W = 48;
    localparam int MUL_W  = 64;
    localparam int HALF_W = MUL_W / 2;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MAX48   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] CAP62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ALL64   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] CFG_STEP_SIZE      = 2'd0;
    localparam logic [1:0] CFG_L1_WEIGHT      = 2'd1;
    localparam logic [1:0] CFG_DIFF_THRESHOLD = 2'd2;

endpackage

`default_nettype wire

// ===== design/fista_l1_coefficient_update.sv =====
// ----------------------------------------------------------------------------
// fista_l1_coefficient_update
// One FISTA step with soft threshold on a coefficient vector held in two
// on-chip memories, fed one gradient element per item.
// ----------------------------------------------------------------------------
//
//  channel | valid / ready             | payload
//  --------+---------------------------+---------------------------------------
//  input   | i_in_valid  / o_in_ready  | i_gradient, i_last_element
//  result  | o_out_valid / i_out_ready | o_new_coefficient, o_element_index,
//          |                           | o_vector_done, o_converged, o_pass_count
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  On the vector's first element an item also waits for the tk_next square
//  root, 64 steps, and the momentum divide, 32 steps; on its last, for the
//  convergence bound. No new item is taken until the element is done. Every
//  product goes through the one shared multiplier, built on a 32 x 32 product.
//  After reset a clearing pass writes zero to all 1024 entries of both
//  memories, during which no item is accepted.
//  A finished result waits in the output register; the next item is taken
//  meanwhile, and its result waits until the previous one has gone.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fista_l1_coefficient_update_defines.svh"

module fista_l1_coefficient_update
    import fl1cu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input items
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [47:0]   i_gradient,
    input  wire logic                 i_last_element,
    // result items
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [47:0]        o_new_coefficient,
    output logic [9:0]                o_element_index,
    output logic                      o_vector_done,
    output logic                      o_converged,
    output logic [31:0]               o_pass_count,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [47:0]          i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SQ, S_SQRT, S_TN, S_DINIT, S_DIV, S_READ,
        S_GM, S_TH, S_DIFF, S_ZM, S_CH, S_NM, S_TS, S_BD, S_OUT
    } t_state;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(VECTOR_LENGTH - 1);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    // (a*b) >> 32 capped
    function automatic logic [63:0] q32_cap(input logic [PROD_W-1:0] p,
                                            input logic [63:0] cap);
        logic [63:0] r;
        r = p[95:32];
        if (|p[PROD_W-1:96]) begin
            return cap;
        end
        return (r > cap) ? cap : r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > $signed({18'd0, MAX48[47:0]})) begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (v < $signed({{18{1'b1}}, 48'h8000_0000_0000})) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL64 : s[63:0];
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state              r_state;
    logic [POS_W-1:0]    r_clr;
    logic [POS_W-1:0]    r_pos;
    logic [47:0]         r_step_size;
    logic [47:0]         r_l1_weight;
    logic [32:0]         r_diff_thr;
    logic [47:0]         r_tk;
    logic [47:0]         r_tkn;
    logic [31:0]         r_mom;
    logic [63:0]         r_chg;
    logic [63:0]         r_nrm;
    logic [31:0]         r_pass;

    logic signed [47:0]  r_g;
    logic                r_last;
    logic signed [47:0]  r_oldx;
    logic signed [47:0]  r_z;
    logic signed [47:0]  r_v;
    logic signed [47:0]  r_x;
    logic signed [48:0]  r_diff;
    logic                r_conv;

    logic [127:0]        r_sqn;
    logic [67:0]         r_srem;
    logic [63:0]         r_root;
    logic [48:0]         r_drem;
    logic [31:0]         r_q;
    logic [5:0]          r_cnt;

    logic                r_mst;
    logic [63:0]         r_ma;
    logic [63:0]         r_mb;

    logic                r_ovalid;

    // memories
    logic [47:0]         mem_c [VECTOR_LENGTH];
    logic [47:0]         mem_m [VECTOR_LENGTH];
    logic [47:0]         r_rd_c;
    logic [47:0]         r_rd_m;

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    logic                mul_done;
    logic [PROD_W-1:0]   prod;

    fl1cu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mst),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic                in_acc;
    logic                cfg_acc;
    logic                out_free;
    logic                vend;
    logic [47:0]         g_mag;
    logic [63:0]         sc_m;
    logic signed [65:0]  sc_s;
    logic signed [65:0]  v_wide;
    logic signed [65:0]  zn_wide;
    logic [63:0]         thr;
    logic [47:0]         av;
    logic [47:0]         xm;
    logic signed [47:0]  x_c;
    logic signed [48:0]  diff_c;
    logic [48:0]         diff_mag;
    logic [47:0]         oldx_mag;
    logic signed [47:0]  zn;
    logic [32:0]         thr_in;
    logic [63:0]         bound;
    logic [67:0]         sq_sh;
    logic [67:0]         sq_trial;
    logic                sq_ge;
    logic [64:0]         tn_sum;
    logic [63:0]         tn_half;
    logic [47:0]         tn_c;
    logic [47:0]         drem0;
    logic [48:0]         div_sh;
    logic                div_ge;
    logic                mem_we;
    logic [POS_W-1:0]    mem_addr;
    logic [47:0]         mem_wc;
    logic [47:0]         mem_wm;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign vend     = r_last || (r_pos == LAST_POS);

    // v = z - step * g
    assign g_mag  = r_g[47] ? 48'(-r_g) : 48'(r_g);
    assign sc_m   = q32_cap(prod, CAP62);
    assign sc_s   = $signed({2'b00, sc_m});
    assign v_wide = {{18{r_z[47]}}, r_z} - (r_g[47] ? -sc_s : sc_s);

    // soft threshold; a tie gives zero
    assign thr = q32_cap(prod, MAX48);
    assign av  = r_v[47] ? 48'(-r_v) : 48'(r_v);
    assign xm  = av - thr[47:0];
    always_comb begin
        if ({16'd0, av} <= thr) begin
            x_c = '0;
        end else begin
            x_c = r_v[47] ? -$signed(xm) : $signed(xm);
        end
    end

    assign diff_c   = {r_x[47], r_x} - {r_oldx[47], r_oldx};
    assign diff_mag = r_diff[48] ? 49'(-r_diff) : 49'(r_diff);
    assign oldx_mag = r_oldx[47] ? 48'(-r_oldx) : 48'(r_oldx);

    // z' = x + momentum * diff
    assign zn_wide = {{18{r_x[47]}}, r_x} + (r_diff[48] ? -sc_s : sc_s);
    assign zn      = sat48(zn_wide);

    assign thr_in = (r_diff_thr > ONE_Q32[32:0]) ? ONE_Q32[32:0] : r_diff_thr;
    assign bound  = (thr_in == ONE_Q32[32:0]) ? r_nrm : prod[127:64];

    // square root, two radicand bits a step
    assign sq_sh    = {r_srem[65:0], r_sqn[127:126]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign tn_sum  = {1'b0, r_root} + {1'b0, ONE_Q32};
    assign tn_half = tn_sum[64:1];
    always_comb begin
        if (tn_half > MAX48) begin
            tn_c = MAX48[47:0];
        end else if (tn_half == '0) begin
            tn_c = 48'd1;
        end else begin
            tn_c = tn_half[47:0];
        end
    end

    always_comb begin
        drem0 = (r_tk >= ONE_Q32[47:0]) ? (r_tk - ONE_Q32[47:0]) : '0;
        if (drem0 >= r_tkn) begin
            drem0 = r_tkn - 48'd1;
        end
    end

    // restoring divide, one quotient bit a step
    assign div_sh = {r_drem[47:0], 1'b0};
    assign div_ge = (div_sh >= {1'b0, r_tkn});

    // ------------------------------------------------------------------
    // memories: one write and one read a cycle
    // ------------------------------------------------------------------
    assign mem_we   = (r_state == S_CLEAR) || ((r_state == S_ZM) && mul_done);
    assign mem_addr = (r_state == S_CLEAR) ? r_clr : r_pos;
    assign mem_wc   = (r_state == S_CLEAR) ? '0 : r_x;
    assign mem_wm   = (r_state == S_CLEAR) ? '0 : zn;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_c[mem_addr] <= mem_wc;
            mem_m[mem_addr] <= mem_wm;
        end
        // read the current element continuously; the read is settled
        // by the time the sequencer reaches S_READ
        r_rd_c <= mem_c[r_pos];
        r_rd_m <= mem_m[r_pos];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_mst       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_step_size <= 48'd4295;
            r_l1_weight <= '0;
            r_diff_thr  <= '0;
            r_tk        <= ONE_Q32[47:0];
            r_tkn       <= ONE_Q32[47:0];
            r_mom       <= '0;
            r_chg       <= '0;
            r_nrm       <= '0;
            r_pass      <= '0;
            r_cnt       <= '0;
        end else begin
            r_mst <= 1'b0;

            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_STEP_SIZE:      r_step_size <= i_cfg_data;
                    CFG_L1_WEIGHT:      r_l1_weight <= i_cfg_data;
                    CFG_DIFF_THRESHOLD: r_diff_thr  <= i_cfg_data[32:0];
                    default:            ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_POS) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_acc) begin
                        r_g    <= i_gradient;
                        r_last <= i_last_element;
                        if (r_pos == '0) begin
                            // new vector: start tk^2
                            r_ma    <= 64'(r_tk);
                            r_mb    <= 64'(r_tk);
                            r_mst   <= 1'b1;
                            r_state <= S_SQ;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end

                S_SQ: begin
                    if (mul_done) begin
                        r_sqn   <= {prod[125:0], 2'b00} + {63'd0, 1'b1, 64'd0};
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    r_srem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                    r_root <= {r_root[62:0], sq_ge};
                    r_sqn  <= {r_sqn[125:0], 2'b00};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_TN;
                    end
                end

                S_TN: begin
                    r_tkn   <= tn_c;
                    r_state <= S_DINIT;
                end

                S_DINIT: begin
                    r_drem  <= {1'b0, drem0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_drem <= div_ge ? (div_sh - {1'b0, r_tkn}) : div_sh;
                    r_q    <= {r_q[30:0], div_ge};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt[4:0] == 5'd31) begin
                        r_mom   <= {r_q[30:0], div_ge};
                        r_state <= S_READ;
                    end
                end

                S_READ: begin
                    r_oldx  <= r_rd_c;
                    r_z     <= r_rd_m;
                    r_ma    <= 64'(g_mag);
                    r_mb    <= 64'(r_step_size);
                    r_mst   <= 1'b1;
                    r_state <= S_GM;
                end

                S_GM: begin
                    if (mul_done) begin
                        r_v     <= sat48(v_wide);
                        r_ma    <= 64'(r_l1_weight);
                        r_mb    <= 64'(r_step_size);
                        r_mst   <= 1'b1;
                        r_state <= S_TH;
                    end
                end

                S_TH: begin
                    if (mul_done) begin
                        r_x     <= x_c;
                        r_state <= S_DIFF;
                    end
                end

                S_DIFF: begin
                    r_diff  <= diff_c;
                    r_ma    <= 64'(diff_c[48] ? 49'(-diff_c) : 49'(diff_c));
                    r_mb    <= 64'(r_mom);
                    r_mst   <= 1'b1;
                    r_state <= S_ZM;
                end

                S_ZM: begin
                    // write-back happens in the memory block on this edge
                    if (mul_done) begin
                        r_ma    <= 64'(diff_mag);
                        r_mb    <= 64'(diff_mag);
                        r_mst   <= 1'b1;
                        r_state <= S_CH;
                    end
                end

                S_CH: begin
                    if (mul_done) begin
                        r_chg   <= sat_add64(r_chg, q32_cap(prod, ALL64));
                        r_ma    <= 64'(oldx_mag);
                        r_mb    <= 64'(oldx_mag);
                        r_mst   <= 1'b1;
                        r_state <= S_NM;
                    end
                end

                S_NM: begin
                    if (mul_done) begin
                        r_nrm <= sat_add64(r_nrm, q32_cap(prod, ALL64));
                        if (vend) begin
                            r_ma    <= 64'(thr_in);
                            r_mb    <= 64'(thr_in);
                            r_mst   <= 1'b1;
                            r_state <= S_TS;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end

                S_TS: begin
                    if (mul_done) begin
                        r_ma    <= prod[63:0];
                        r_mb    <= r_nrm;
                        r_mst   <= 1'b1;
                        r_state <= S_BD;
                    end
                end

                S_BD: begin
                    if (mul_done) begin
                        r_conv  <= (r_chg < bound);
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (out_free) begin
                        r_ovalid          <= 1'b1;
                        o_new_coefficient <= r_x;
                        o_element_index   <= 10'(r_pos);
                        o_vector_done     <= vend;
                        o_converged       <= vend && r_conv;
                        if (vend) begin
                            // close the vector
                            o_pass_count <= r_pass + 32'd1;
                            r_pass       <= r_pass + 32'd1;
                            r_tk         <= r_tkn;
                            r_chg        <= '0;
                            r_nrm        <= '0;
                            r_pos        <= '0;
                        end else begin
                            o_pass_count <= r_pass;
                            r_pos        <= r_pos + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FL1CU_ASSERT_IMP(a_conv_only_at_end, i_clk, i_rst_n, o_out_valid && o_converged, o_vector_done, "converged without vector end")
    `FL1CU_ASSERT_NXT(a_vector_close, i_clk, i_rst_n, (r_state == S_OUT) && out_free && vend, (r_pos == '0) && (r_chg == '0) && (r_nrm == '0), "vector end did not clear position and sums")
    `FL1CU_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_tkn != '0, "momentum divide by zero")
    `FL1CU_ASSERT_IMP(a_mul_expected, i_clk, i_rst_n, mul_done, (r_state == S_SQ) || (r_state == S_GM) || (r_state == S_TH) || (r_state == S_ZM) || (r_state == S_CH) || (r_state == S_NM) || (r_state == S_TS) || (r_state == S_BD), "product finished with no waiting step")

endmodule

`default_nettype wire

// ===== design/fl1cu_mul.sv =====
// ----------------------------------------------------------------------------
// fl1cu_mul
// Unsigned 64 x 64 multiplier built from one 32 x 32 product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fl1cu_mul
    import fl1cu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [2:0]        r_step;
    logic              r_busy;
    logic              r_ppv;
    logic [1:0]        r_pk;
    logic [MUL_W-1:0]  r_pp;
    logic [PROD_W-1:0] r_acc;
    logic              r_done;

    logic [HALF_W-1:0] a_part;
    logic [HALF_W-1:0] b_part;
    logic [PROD_W-1:0] pp_shifted;

    // partial order: lo*lo, lo*hi, hi*lo, hi*hi
    assign a_part = r_step[1] ? r_a[MUL_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_part = r_step[0] ? r_b[MUL_W-1:HALF_W] : r_b[HALF_W-1:0];

    always_comb begin
        unique case (r_pk)
            2'd0:    pp_shifted = {{MUL_W{1'b0}}, r_pp};
            2'd3:    pp_shifted = {r_pp, {MUL_W{1'b0}}};
            default: pp_shifted = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ppv  <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_ppv <= (r_step < 3'd4);
                if (r_step < 3'd4) begin
                    r_step <= r_step + 3'd1;
                end
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step < 3'd4) begin
                r_pp <= a_part * b_part;
                r_pk <= r_step[1:0];
            end
            if (r_ppv) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== tb/fista_l1_coefficient_update_test.sv =====
// ----------------------------------------------------------------------------
// FISTA L1 coefficient update - self-checking testbench
// Streams gradient vectors through the block under several register settings
// and idling patterns. Each accepted element is run through a fixed-point
// FISTA step here, and the result the block returns is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fista_l1_coefficient_update_test;
    import fl1cu_pkg::*;

    localparam int IDLE_LIMIT = 60000;   // cycles without any accepted item
    localparam int SETTLE     = 200;     // margin beyond the longest element

    typedef struct {
        logic signed [47:0] grad;
        logic               last;
    } t_gradient_item;

    typedef struct {
        logic signed [47:0] coef;
        logic [9:0]         index;
        logic               done;
        logic               conv;
        logic [31:0]        passes;
    } t_coefficient_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic signed [47:0]  i_gradient = '0;
    logic                i_last_element = 1'b0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [1:0]          i_cfg_index = CFG_STEP_SIZE;
    logic [47:0]         i_cfg_data = '0;
    logic                o_in_ready, o_out_valid, o_vector_done, o_converged, o_cfg_ready;
    logic signed [47:0]  o_new_coefficient;
    logic [9:0]          o_element_index;
    logic [31:0]         o_pass_count;

    fista_l1_coefficient_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_gradient(i_gradient), .i_last_element(i_last_element),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_new_coefficient(o_new_coefficient), .o_element_index(o_element_index),
        .o_vector_done(o_vector_done), .o_converged(o_converged),
        .o_pass_count(o_pass_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted state of the block
    // ------------------------------------------------------------------
    logic [63:0]         step_gamma = 64'd4295;
    logic [63:0]         lambda_l1 = '0;
    logic [63:0]         rel_bound = '0;
    longint              coef_mem [VECTOR_LENGTH];
    longint              accel_mem [VECTOR_LENGTH];
    logic [63:0]         tk = ONE_Q32;
    logic [63:0]         tk_next = ONE_Q32;
    logic [63:0]         momentum = '0;
    int unsigned         position = 0;
    logic [63:0]         change_acc = '0;
    logic [63:0]         norm_acc = '0;
    logic [31:0]         vectors_done = '0;

    t_gradient_item      pending_gradients[$];
    t_coefficient_result expected_coefs[$];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    initial begin
        for (int i = 0; i < VECTOR_LENGTH; i++) begin
            coef_mem[i] = 0;
            accel_mem[i] = 0;
        end
    end

    // (a*b) >> 32 in unsigned arithmetic, capped
    function automatic logic [63:0] q32_product(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:96] != 0) return cap;
        return (p[95:32] > cap) ? cap : p[95:32];
    endfunction

    function automatic longint clamp48(longint v);
        if (v > longint'(MAX48)) return longint'(MAX48);
        if (v < -longint'(MAX48) - 1) return -longint'(MAX48) - 1;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // signed value times unsigned Q.32 factor, rounding toward zero
    function automatic longint scale_q32(longint v, logic [63:0] f);
        longint m;
        m = longint'(q32_product(magnitude(v), f, CAP62));
        return (v < 0) ? -m : m;
    endfunction

    // tk_next = (1 + sqrt(1 + 4 tk^2)) / 2 and momentum = (tk - 1) / tk_next
    task automatic load_vector_factors();
        logic [127:0] radicand, sq;
        logic [63:0]  root, cand, excess;
        logic [95:0]  quot;
        radicand = (({64'd0, tk} * {64'd0, tk}) << 2) + (128'd1 << 64);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= radicand) root = cand;
        end
        tk_next = (ONE_Q32 + root) >> 1;
        if (tk_next > MAX48) tk_next = MAX48;
        if (tk_next == 0) tk_next = 64'd1;
        excess = (tk >= ONE_Q32) ? tk - ONE_Q32 : 64'd0;
        if (excess >= tk_next) excess = tk_next - 1;
        quot = {excess, 32'd0} / {32'd0, tk_next};
        momentum = quot[63:0];
    endtask

    task automatic predict_fista_step(logic signed [47:0] grad, logic last);
        t_coefficient_result r;
        longint      g, old_x, v, x, diff;
        logic [63:0] thr, av, rb, bound;
        logic [127:0] wide;
        int unsigned p;
        g = grad;
        p = (position >= VECTOR_LENGTH) ? 0 : position;
        if (p == 0) load_vector_factors();
        old_x = coef_mem[p];
        v = clamp48(accel_mem[p] - scale_q32(g, step_gamma));
        thr = q32_product(lambda_l1, step_gamma, MAX48);
        av = magnitude(v);
        // a magnitude at or below the threshold shrinks to zero
        if (av <= thr) x = 0;
        else x = (v < 0) ? -longint'(av - thr) : longint'(av - thr);
        diff = x - old_x;
        coef_mem[p] = x;
        accel_mem[p] = clamp48(x + scale_q32(diff, momentum));
        change_acc = change_acc + q32_product(magnitude(diff), magnitude(diff), ALL64);
        if (change_acc < q32_product(magnitude(diff), magnitude(diff), ALL64))
            change_acc = ALL64;
        av = q32_product(magnitude(old_x), magnitude(old_x), ALL64);
        norm_acc = norm_acc + av;
        if (norm_acc < av) norm_acc = ALL64;
        r.coef = x[47:0];
        r.index = p[9:0];
        r.done = last || (p == VECTOR_LENGTH - 1);
        r.conv = 1'b0;
        if (r.done) begin
            // thresholds above one count as one
            rb = (rel_bound > ONE_Q32) ? ONE_Q32 : rel_bound;
            if (rb == ONE_Q32) begin
                bound = norm_acc;
            end else begin
                wide = {64'd0, rb * rb} * {64'd0, norm_acc};
                bound = wide[127:64];
            end
            r.conv = change_acc < bound;
            tk = tk_next;
            vectors_done = vectors_done + 1;
            change_acc = '0;
            norm_acc = '0;
            position = 0;
        end else begin
            position = p + 1;
        end
        r.passes = vectors_done;
        expected_coefs.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: hold each item until accepted, then take the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_gradient_item nxt;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predict_fista_step(i_gradient, i_last_element);
            if (!i_in_valid || o_in_ready) begin
                if (pending_gradients.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_gradients.pop_front();
                    i_gradient <= nxt.grad;
                    i_last_element <= nxt.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_coefficient_result e;
        if (i_rst_n) begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                if (expected_coefs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing predicted: index %0d coef %0d",
                                 o_element_index, o_new_coefficient);
                end else begin
                    e = expected_coefs.pop_front();
                    if (o_new_coefficient !== e.coef || o_element_index !== e.index ||
                        o_vector_done !== e.done || o_converged !== e.conv ||
                        o_pass_count !== e.passes) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp coef %0d idx %0d done %0b conv %0b passes %0d",
                                     e.coef, e.index, e.done, e.conv, e.passes);
                            $display("          got coef %0d idx %0d done %0b conv %0b passes %0d",
                                     o_new_coefficient, o_element_index, o_vector_done,
                                     o_converged, o_pass_count);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_gradient(logic signed [47:0] g, logic last);
        t_gradient_item it;
        it.grad = g;
        it.last = last;
        pending_gradients.push_back(it);
    endtask

    function automatic logic signed [47:0] random_gradient();
        logic signed [47:0] g;
        int sel;
        g = 48'({$urandom(), $urandom()});
        sel = $urandom_range(9);
        if (sel < 5) g = 48'(longint'($urandom_range(1 << 30)) * 16 - (longint'(1) << 34));
        else if (sel < 7) g = g >>> $urandom_range(20);
        else if (sel == 7) g = $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
        return g;
    endfunction

    // random vector of mostly short length, sometimes cut short by noise
    task automatic queue_vector();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++)
            queue_gradient(random_gradient(), (i == len - 1) || ($urandom_range(30) == 0));
    endtask

    // wait until every item has gone in and every result has come back
    task automatic drain();
        while (pending_gradients.size() > 0 || i_in_valid || expected_coefs.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [47:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP_SIZE:      step_gamma = {16'd0, value};
            CFG_L1_WEIGHT:      lambda_l1 = {16'd0, value};
            CFG_DIFF_THRESHOLD: rel_bound = {31'd0, value[32:0]};
            default: ;
        endcase
    endtask

    task automatic configure(logic [47:0] step, logic [47:0] lambda, logic [47:0] thr);
        write_register(CFG_STEP_SIZE, step);
        write_register(CFG_L1_WEIGHT, lambda);
        write_register(CFG_DIFF_THRESHOLD, thr);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes
        queue_gradient(48'sh0, 1'b0);
        queue_gradient(48'sh7FFF_FFFF_FFFF, 1'b0);
        queue_gradient(48'sh8000_0000_0000, 1'b0);
        queue_gradient(48'sh1, 1'b0);
        queue_gradient(-48'sh1, 1'b1);
        queue_gradient(48'sh8000_0000_0000, 1'b0);
        queue_gradient(48'sh7FFF_FFFF_FFFF, 1'b1);
        drain();

        // unit step and unit penalty: exact threshold ties, full threshold
        configure(48'h1_0000_0000, 48'h1_0000_0000, 48'h1_0000_0000);
        for (int k = 0; k < 3; k++) begin
            queue_gradient(-48'sh1_0000_0000, 1'b0);
            queue_gradient(48'sh1_0000_0000, 1'b0);
            queue_gradient(-48'sh3_0000_0000, 1'b0);
            queue_gradient(48'sh5_0000_0000, 1'b1);
        end
        drain();

        // largest step, no penalty, threshold over one: saturation everywhere
        configure(48'hFFFF_FFFF_FFFF, 48'h0, 48'h1_FFFF_FFFF);
        queue_gradient(48'sh0000_0001_0000, 1'b0);
        queue_gradient(-48'sh0000_0001_0000, 1'b1);
        queue_gradient(48'sh0, 1'b1);
        drain();

        // one vector running the full length without a last marker
        configure(48'h0000_1000_0000, 48'h0000_4000_0000, 48'h0000_8000_0000);
        for (int i = 0; i < VECTOR_LENGTH; i++) queue_gradient(random_gradient(), 1'b0);
        drain();

        // random vectors under several settings and idling patterns
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: configure(48'h0, 48'hFFFF_FFFF_FFFF, 48'h0);
                1: configure(48'h0000_0800_0000, 48'h0000_0100_0000, 48'h0_4000_0000);
                2: configure(48'h0001_0000_0000, 48'h0, 48'h0_F000_0000);
                3: configure({16'd0, $urandom()}, {16'd0, $urandom()},
                             {15'd0, 1'($urandom_range(1)), $urandom()});
                default: configure(48'h0000_2000_0000, 48'h0000_0010_0000, 48'h1_0000_0000);
            endcase
            send_idle_pct = (ph == 1 || ph == 3) ? 87 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 30 : 87) : 0;
            if (ph == 3) send_idle_pct = 30;
            if (ph == 4) begin
                // hold off the sender until each vector has fully come back
                for (int n = 0; n < 15; n++) begin
                    queue_vector();
                    while (pending_gradients.size() > 0 || i_in_valid ||
                           expected_coefs.size() > 0)
                        @(posedge i_clk);
                end
            end else begin
                for (int n = 0; n < 22; n++) queue_vector();
            end
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/fl1cu_pkg.sv
design/fl1cu_mul.sv
design/fista_l1_coefficient_update.sv
tb/fista_l1_coefficient_update_test.sv
